>>> rtl/mexp_pkg.sv
// mexp_pkg: shared types for the modular exponentiation block
// no dependencies
package mexp_pkg;
    typedef enum logic [2:0] {
        t_idle_st  = 3'd0,
        t_rbase_st = 3'd1,
        t_mul_st   = 3'd2,
        t_sqr_st   = 3'd3,
        t_done_st  = 3'd4
    } t_state;
endpackage

>>> rtl/modular_exponentiation.sv
// modular_exponentiation: top level, square-and-multiply sequencer
// depends on mexp_pkg, mexp_mulmod, mexp_cell
//
// usage:
//   input channel i_valid/o_ready carries base, exponent, modulus; output
//   channel o_valid/i_ready carries power_mod and bad_modulus, one beat out
//   per beat in. one item is worked at a time.
// sequence:
//   modulus or exponent zero: straight to the result. otherwise the base is
//   first reduced by one modular product with 1, then each exponent bit up to
//   the highest set one costs a square and, when set, a multiply. one modular
//   product runs one double step of the cell row per multiplier bit and one
//   add step per set bit.
// what sets the pace: the single shared multiplier row of WIDTH+2 cells
// reset: synchronous active low, returns to idle with no pending result
// stall: the result register holds while i_ready is low; o_ready stays low
//   until the result beat is taken
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_base,
    input  logic [31:0] i_exponent,
    input  logic [31:0] i_modulus,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_power_mod,
    output logic        o_bad_modulus
);
    import mexp_pkg::*;

    t_state r_state, n_state;
    logic [WIDTH-1:0] r_b, r_e, r_m, r_acc;
    logic [31:0] r_out;
    logic r_bad, r_val, n_val;
    logic w_start;
    logic [WIDTH-1:0] w_x, w_y, w_m;
    logic w_done;
    logic [WIDTH-1:0] w_p;
    logic [WIDTH-1:0] w_one;
    logic [WIDTH-1:0] w_in_b, w_in_e, w_in_m;

    assign w_one  = WIDTH'(1);
    // operands taken at the block width
    assign w_in_b = WIDTH'(i_base);
    assign w_in_e = WIDTH'(i_exponent);
    assign w_in_m = WIDTH'(i_modulus);

    mexp_mulmod #(.WIDTH(WIDTH)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_x(w_x), .i_y(w_y), .i_m(w_m), .o_done(w_done), .o_p(w_p)
    );

    wire w_acc_in = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_idle_st: if (w_acc_in) begin
                if (w_in_m == '0 || w_in_e == '0)
                    n_state = t_done_st;
                else n_state = t_rbase_st;
            end
            t_rbase_st: if (w_done) n_state = r_e[0] ? t_mul_st : t_sqr_st;
            t_mul_st: if (w_done) n_state = t_sqr_st;
            t_sqr_st: if (w_done) n_state = (r_e[WIDTH-1:1] == '0) ? t_done_st
                                             : (r_e[1] ? t_mul_st : t_sqr_st);
            t_done_st: n_state = t_idle_st;
            default: n_state = t_idle_st;
        endcase
    end

    // outputs to the multiplier
    always_comb begin
        w_start = 1'b0;
        w_x = r_acc;
        w_y = r_b;
        w_m = r_m;
        case (r_state)
            t_idle_st: begin
                // base reduction starts straight from the input beat
                w_x = w_one;
                w_y = w_in_b;
                w_m = w_in_m;
                w_start = w_acc_in && w_in_m != '0 && w_in_e != '0;
            end
            t_rbase_st: begin
                w_x = w_p;
                w_y = w_p;
                w_start = w_done;
                if (w_done && r_e[0]) begin w_x = w_one; w_y = w_p; end
            end
            t_mul_st: begin
                w_x = r_b; w_y = r_b; w_start = w_done;
            end
            t_sqr_st: begin
                w_x = r_acc; w_y = w_p;
                w_start = w_done && (r_e[WIDTH-1:1] != '0);
                if (w_done && !r_e[1]) begin w_x = w_p; w_y = w_p; end
            end
            default: w_start = 1'b0;
        endcase
    end

    always_comb begin
        n_val = r_val;
        if (o_valid && i_ready) n_val = 1'b0;
        if (r_state == t_done_st) n_val = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle_st;
            r_val   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_val   <= n_val;
        end
    end

    // datapath; first product computes base*1 mod m
    always_ff @(posedge i_clk) begin
        case (r_state)
            t_idle_st: if (w_acc_in) begin
                r_b   <= w_in_b;
                r_e   <= w_in_e;
                r_m   <= w_in_m;
                r_acc <= w_one;
                r_bad <= (w_in_m == '0);
            end
            t_rbase_st: if (w_done) r_b <= w_p;
            t_mul_st: if (w_done) r_acc <= w_p;
            t_sqr_st: if (w_done) begin
                r_b <= w_p;
                r_e <= r_e >> 1;
            end
            t_done_st: r_out <= r_bad ? 32'd0 : 32'(r_acc);
            default: r_acc <= r_acc;
        endcase
    end

    assign o_ready       = (r_state == t_idle_st) && !r_val;
    assign o_valid       = r_val;
    assign o_power_mod   = r_out;
    assign o_bad_modulus = r_bad;
endmodule

>>> rtl/mexp_cell.sv
// mexp_cell: one bit slice of the shift-subtract modular multiplier chain
// no dependencies
module mexp_cell (
    input  logic i_acc,      // accumulator bit (doubled position in the double phase)
    input  logic i_add,      // addend bit
    input  logic i_m,        // modulus bit
    input  logic i_cin,
    input  logic i_bin,
    output logic o_sum,
    output logic o_cout,
    output logic o_diff,
    output logic o_bout
);
    logic w_s;
    always_comb begin
        w_s    = i_acc ^ i_add ^ i_cin;
        o_cout = (i_acc & i_add) | (i_cin & (i_acc ^ i_add));
        o_sum  = w_s;
        o_diff = w_s ^ i_m ^ i_bin;
        o_bout = (~w_s & i_m) | (i_bin & ~(w_s ^ i_m));
    end
endmodule

>>> rtl/mexp_mulmod.sv
// mexp_mulmod: (x*y) mod m, one multiplier bit at a time, through a row of cells
// depends on mexp_cell
module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_p
);
    localparam int CW = $clog2(WIDTH + 1);
    localparam int AW = WIDTH + 2;

    logic [WIDTH-1:0] r_acc, n_acc, r_y, r_x, r_m;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic             r_phase, n_phase; // 0: double, 1: add

    logic [AW-1:0] w_a, w_b, w_mm, w_sum, w_diff;
    logic [AW:0]   w_c, w_bw;

    always_comb begin
        w_a  = r_phase ? {2'b00, r_acc} : {1'b0, r_acc, 1'b0};
        w_b  = r_phase ? {2'b00, r_x} : '0;
        w_mm = {2'b00, r_m};
    end

    assign w_c[0]  = 1'b0;
    assign w_bw[0] = 1'b0;
    genvar g;
    generate
        for (g = 0; g < AW; g++) begin : g_row
            mexp_cell u_cell (
                .i_acc (w_a[g]), .i_add(w_b[g]), .i_m(w_mm[g]),
                .i_cin (w_c[g]), .i_bin(w_bw[g]),
                .o_sum (w_sum[g]), .o_cout(w_c[g+1]),
                .o_diff(w_diff[g]), .o_bout(w_bw[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_acc = r_acc; n_cnt = r_cnt; n_busy = r_busy;
        n_done = 1'b0; n_phase = r_phase;
        if (i_start) begin
            n_acc = '0; n_cnt = CW'(WIDTH); n_busy = 1'b1; n_phase = 1'b0;
        end else if (r_busy) begin
            // below 2m, one conditional subtract
            n_acc = w_bw[AW] ? w_sum[WIDTH-1:0] : w_diff[WIDTH-1:0];
            if (!r_phase) begin
                if (r_y[WIDTH-1]) n_phase = 1'b1;
                else begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin n_busy = 1'b0; n_done = 1'b1; end
                end
            end else begin
                n_phase = 1'b0;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin n_busy = 1'b0; n_done = 1'b1; end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_phase <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_phase <= n_phase; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_start) begin
            r_x <= i_x; r_y <= i_y; r_m <= i_m;
        end else if (r_busy && (r_phase || !r_y[WIDTH-1])) begin
            r_y <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule
